>>> hw/rtl/pc1c_pkg.sv
// ============================================================================
// pc1c_pkg - shared definitions for the predictor-1 compressor
// Group size, counter widths, input kind codes and the group record that
// passes from the collecting side to the burst output stage.
// ============================================================================
package pc1c_pkg;

    localparam int GROUP_SIZE    = 8;
    localparam int CNT_W         = $clog2(GROUP_SIZE + 1);
    localparam int GIDX_W        = $clog2(GROUP_SIZE);
    localparam int DEF_HASH_BITS = 16;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // One closed group: flag byte, held literals in arrival order, their
    // count and whether the group closes a frame.
    typedef struct packed {
        logic                       eof;
        logic [CNT_W-1:0]           lcount;
        logic [7:0]                 flags;
        logic [GROUP_SIZE-1:0][7:0] lits;
    } t_group;

endpackage

>>> hw/rtl/pc1c_burst.sv
// ============================================================================
// pc1c_burst - group burst output stage
// Holds one closed group and plays it out as the flag byte followed by the
// held literals, one transfer per cycle while m_axis_tready is high.
// ============================================================================
module pc1c_burst (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  pc1c_pkg::t_group i_grp,
    output logic            o_free,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      m_axis_tuser,   // [0] is_flag, [1] frame_last
    output logic            m_axis_tlast    // group_last
);
    import pc1c_pkg::*;

    logic              r_valid;
    logic [CNT_W-1:0]  r_idx;
    t_group            r_grp;
    logic              m_fire;
    logic              last;
    logic [GIDX_W-1:0] lit_sel;

    assign m_fire  = m_axis_tvalid && m_axis_tready;
    assign last    = (r_idx == r_grp.lcount);
    assign o_free  = !r_valid || (m_fire && last);
    // index 1..GROUP_SIZE maps onto literal 0..GROUP_SIZE-1
    assign lit_sel = r_idx[GIDX_W-1:0] - GIDX_W'(1);

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = (r_idx == '0) ? r_grp.flags : r_grp.lits[lit_sel];
    assign m_axis_tuser  = {r_grp.eof && last, r_idx == '0};
    assign m_axis_tlast  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (m_fire) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

    a_idx_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx <= r_grp.lcount)
        else $error("burst index past literal count");

    a_load_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("group loaded over a burst in progress");

    a_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_fire && !last && !i_load) |=> r_valid && (r_idx == $past(r_idx) + CNT_W'(1)))
        else $error("burst index did not advance");

endmodule

>>> hw/rtl/predictor_one_compressor_core.sv
// ============================================================================
// predictor_one_compressor_core - predictor-1 compression core
// Byte-wise predictor-1 compression: a guess table indexed by a rolling
// hash marks matching bytes in a group flag byte and holds missing bytes as
// literals; each closed group leaves as flag byte then literals.
// ============================================================================
//
//  channel   dir  fields (tdata / tuser / tlast)
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   data_byte / kind (0 data, 1 clear history) / end_of_frame
//  m_axis    out  out_byte / {frame_last, is_flag} / group_last
//
//  One input transfer per cycle unless s_axis_tready is held low: the
//  table is read at accept and written back from the second stage, with a
//  same-address hit forwarded to the next byte. Output runs at one transfer
//  per cycle while m_axis_tready is high; the one burst buffer limits group
//  throughput. Reset and every clear-history item start a table sweep over
//  all 2^HASH_BITS entries (one entry a cycle), holding s_axis_tready low.
//  A closing byte waits in the second stage while a previous burst drains.
//
module predictor_one_compressor_core #(
    parameter int HASH_BITS = pc1c_pkg::DEF_HASH_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] kind
    input  logic       s_axis_tlast,   // end_of_frame
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] is_flag, [1] frame_last
    output logic       m_axis_tlast    // group_last
);
    import pc1c_pkg::*;

    localparam int DEPTH = 1 << HASH_BITS;

    // guess table: one write port, one registered read port
    logic [7:0] r_table [DEPTH];
    logic [7:0] r_rd_data;

    // table sweep after reset and on clear history
    logic                 r_sweep;
    logic [HASH_BITS-1:0] r_sweep_addr;

    logic [HASH_BITS-1:0] r_hash;

    // second stage: compare, write back, group update
    logic                 r_b_valid;
    logic                 r_b_clear;
    logic [7:0]           r_b_byte;
    logic                 r_b_eof;
    logic [HASH_BITS-1:0] r_b_addr;
    logic                 r_b_fwd;
    logic [7:0]           r_b_fwd_data;

    // group being collected
    logic [7:0]                 r_flags;
    logic [CNT_W-1:0]           r_gcount;
    logic [CNT_W-1:0]           r_lcount;
    logic [GROUP_SIZE-1:0][7:0] r_lit;

    logic                 s_fire;
    logic                 b_fire;
    logic                 b_data;
    logic                 b_miss;
    logic                 b_close;
    logic                 b_wr_en;
    logic [7:0]           b_guess;
    logic                 burst_free;
    logic                 burst_load;
    t_group               grp;
    logic [7:0]           n_flags;
    logic [CNT_W-1:0]     n_lcount;
    logic [HASH_BITS-1:0] n_hash;
    logic                 mem_we;
    logic [HASH_BITS-1:0] mem_waddr;
    logic [7:0]           mem_wdata;

    // ---- handshake and stage control -------------------------------------
    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign b_data  = r_b_valid && (r_b_clear == KIND_DATA);
    assign b_guess = r_b_fwd ? r_b_fwd_data : r_rd_data;
    assign b_miss  = (b_guess != r_b_byte);
    assign b_close = (r_gcount == CNT_W'(GROUP_SIZE - 1)) || r_b_eof;
    // a closing byte holds until the burst buffer can take the group
    assign b_fire  = r_b_valid && (r_b_clear || !b_close || burst_free);
    assign b_wr_en = b_fire && b_data && b_miss;
    assign burst_load = b_fire && b_data && b_close;

    // no accept during a sweep, nor beside a clear about to start one
    assign s_axis_tready = !r_sweep && !(r_b_valid && r_b_clear)
                         && (!r_b_valid || b_fire);

    assign n_hash = (r_hash << 4) ^ HASH_BITS'(s_axis_tdata);

    // ---- table port ------------------------------------------------------
    assign mem_we    = r_sweep || b_wr_en;
    assign mem_waddr = r_sweep ? r_sweep_addr : r_b_addr;
    assign mem_wdata = r_sweep ? 8'h00 : r_b_byte;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        if (s_fire) begin
            r_rd_data <= r_table[r_hash];
        end
    end

    // ---- sweep and hash --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_sweep) begin
            r_sweep_addr <= r_sweep_addr + HASH_BITS'(1);
            if (r_sweep_addr == '1) begin
                r_sweep <= 1'b0;
            end
        end else if (b_fire && r_b_clear) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (s_fire) begin
            r_hash <= (s_axis_tuser == KIND_CLEAR) ? '0 : n_hash;
        end
    end

    // ---- second stage ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (s_fire) begin
            r_b_valid <= 1'b1;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    // The read at accept misses a write-back landing on the same edge:
    // capture that byte alongside the item.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_b_clear    <= s_axis_tuser;
            r_b_byte     <= s_axis_tdata;
            r_b_eof      <= s_axis_tlast;
            r_b_addr     <= r_hash;
            r_b_fwd      <= b_wr_en && (r_b_addr == r_hash);
            r_b_fwd_data <= r_b_byte;
        end
    end

    // ---- group collection ------------------------------------------------
    always_comb begin
        n_flags  = r_flags;
        n_lcount = r_lcount;
        if (b_miss) begin
            n_lcount = r_lcount + CNT_W'(1);
        end else begin
            n_flags = r_flags | (8'h01 << r_gcount[GIDX_W-1:0]);
        end
        grp.eof    = r_b_eof;
        grp.lcount = n_lcount;
        grp.flags  = n_flags;
        for (int j = 0; j < GROUP_SIZE; j++) begin
            grp.lits[j] = (b_miss && (r_lcount == CNT_W'(j))) ? r_b_byte : r_lit[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_gcount <= '0;
            r_lcount <= '0;
        end else if (b_fire && b_data) begin
            if (b_close) begin
                r_flags  <= '0;
                r_gcount <= '0;
                r_lcount <= '0;
            end else begin
                r_flags  <= n_flags;
                r_gcount <= r_gcount + CNT_W'(1);
                r_lcount <= n_lcount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire && b_data && b_miss && !b_close) begin
            r_lit[r_lcount[GIDX_W-1:0]] <= r_b_byte;
        end
    end

    // ---- burst output ----------------------------------------------------
    pc1c_burst u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (burst_load),
        .i_grp         (grp),
        .o_free        (burst_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ---- checks ----------------------------------------------------------
    a_port_clash : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sweep && b_wr_en))
        else $error("sweep and write-back share the table port");

    a_no_accept_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep |-> !s_fire)
        else $error("item accepted during table sweep");

    a_lit_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcount <= r_gcount)
        else $error("more literals than bytes in group");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_fire) |=> r_b_valid && $stable(r_b_byte) && $stable(r_b_addr))
        else $error("stalled second stage lost its item");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for predictor_one_compressor_core
// Drives framed byte traffic and history clears into the compressor,
// predicts every flag and literal byte of the compressed stream and checks
// the output transfers in order, under random stalls on both sides.
// ============================================================================
module tb;
    import pc1c_pkg::*;

    localparam int HASH_W       = DEF_HASH_BITS;
    localparam int RESET_CYCLES = 12;
    // Longest legal quiet spell is a full table sweep; allow it several times.
    localparam int STALL_LIMIT  = 4 * (1 << HASH_W) + 10000;
    localparam int LONG_HOLD    = 600;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_BYTES = 300;
    localparam int QUIET_FROM   = 250;
    localparam int POOL_DEPTH   = 24;

    // One output transfer as the compressor should present it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_flag;
        logic       group_last;
        logic       frame_last;
    } t_out_item;

    // ------------------------------------------------------------------------
    // Compression predictor and store of expected output bytes
    // ------------------------------------------------------------------------
    class compressed_stream_check;
        logic [7:0]        guess [int];
        logic [HASH_W-1:0] hash;
        logic [7:0]        flags;
        int unsigned       bytes_in_group;
        logic [7:0]        literals [GROUP_SIZE];
        int unsigned       n_literals;
        t_out_item         compressed_q [$];
        int                mismatches;
        int                checked;
        int                bytes_taken;
        int                clears_taken;
        int                flag_only_bursts;
        int                frames_closed;

        function new();
            clear_history();
            flags            = '0;
            bytes_in_group   = 0;
            n_literals       = 0;
            mismatches       = 0;
            checked          = 0;
            bytes_taken      = 0;
            clears_taken     = 0;
            flag_only_bursts = 0;
            frames_closed    = 0;
        endfunction

        // Missing entries read as zero, so dropping the table clears it.
        function void clear_history();
            guess.delete();
            hash = '0;
        endfunction

        // Note one accepted input transfer; queue any burst it closes.
        function void take_item(logic kind, logic [7:0] b, logic eof);
            logic [7:0] g;
            t_out_item  r;
            if (kind == KIND_CLEAR) begin
                clear_history();
                clears_taken++;
                return;
            end
            bytes_taken++;
            g = guess.exists(int'(hash)) ? guess[int'(hash)] : 8'h00;
            if (g == b) begin
                flags[bytes_in_group % GROUP_SIZE] = 1'b1;
            end else begin
                guess[int'(hash)] = b;
                if (n_literals < GROUP_SIZE) begin
                    literals[n_literals] = b;
                    n_literals++;
                end
            end
            hash = (hash << 4) ^ {{(HASH_W-8){1'b0}}, b};
            bytes_in_group++;
            if (bytes_in_group < GROUP_SIZE && !eof)
                return;

            r.out_byte   = flags;
            r.is_flag    = 1'b1;
            r.group_last = (n_literals == 0);
            r.frame_last = eof && (n_literals == 0);
            compressed_q.push_back(r);
            for (int i = 0; i < n_literals; i++) begin
                r.out_byte   = literals[i];
                r.is_flag    = 1'b0;
                r.group_last = (i + 1 == n_literals);
                r.frame_last = eof && (i + 1 == n_literals);
                compressed_q.push_back(r);
            end
            if (n_literals == 0)
                flag_only_bursts++;
            if (eof)
                frames_closed++;
            flags          = '0;
            bytes_in_group = 0;
            n_literals     = 0;
        endfunction

        // Compare one accepted output transfer with the oldest expectation.
        function void match_output(t_out_item got);
            t_out_item want;
            if (compressed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output byte %02h flag %0b glast %0b flast %0b",
                             $time, got.out_byte, got.is_flag, got.group_last,
                             got.frame_last);
                return;
            end
            want = compressed_q.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte || got.is_flag !== want.is_flag ||
                got.group_last !== want.group_last || got.frame_last !== want.frame_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch, expected byte %02h flag %0b glast %0b ",
                              "flast %0b, got byte %02h flag %0b glast %0b flast %0b"},
                             $time, want.out_byte, want.is_flag, want.group_last,
                             want.frame_last, got.out_byte, got.is_flag,
                             got.group_last, got.frame_last);
            end
        endfunction

        function int pending();
            return compressed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;     // [7:0] data_byte
    logic       s_axis_tuser  = KIND_DATA; // [0] kind
    logic       s_axis_tlast  = 1'b0;      // end_of_frame
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;              // [7:0] out_byte
    logic [1:0] m_axis_tuser;              // [0] is_flag, [1] frame_last
    logic       m_axis_tlast;              // group_last

    compressed_stream_check stream;

    // Receiver-side controls: idling is switched off for the closing stretch,
    // and each raised request produces one long hold-off.
    bit quiet             = 1'b0;
    int long_holds_asked  = 0;
    int long_holds_done   = 0;
    int hold_left         = 0;
    int idle_cycles       = 0;

    always #1 i_clk = ~i_clk;

    predictor_one_compressor_core #(
        .HASH_BITS (HASH_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // Monitors: sample both channels at the edge, before any driver update
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            stream.take_item(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            stream.match_output(t_out_item'({m_axis_tdata, m_axis_tuser[0],
                                              m_axis_tlast, m_axis_tuser[1]}));
    end

    // Watchdog: count edges with no transfer on either side. The table sweep
    // after reset and after each clear is the longest legitimate silence.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, a long hold on request so the block backs
    // up into its input, and none once quiet is set.
    always @(posedge i_clk) begin
        if (long_holds_done < long_holds_asked) begin
            long_holds_done++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    // Offer one item and hold it until the transfer completes.
    task automatic send_item(input logic kind, input logic [7:0] b, input logic eof);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid for a random burst now and then, unless in the quiet stretch.
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every queued output byte has been seen.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (stream.pending() != 0);
    endtask

    // Directed opening: zero and all-ones bytes, a frame end inside a group,
    // a clear that lands mid-group (partial group survives) with its data and
    // end flag set to be ignored, a group filled exactly on a frame end, a
    // flag-only burst mid-frame and a full group with one literal closing a frame.
    task automatic run_directed();
        send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'hFF, 1'b0);
        send_item(KIND_DATA, 8'hA5, 1'b1);
        send_item(KIND_DATA, 8'h3A, 1'b0);
        send_item(KIND_DATA, 8'hC3, 1'b0);
        send_item(KIND_DATA, 8'h7E, 1'b0);
        send_item(KIND_CLEAR, 8'hFF, 1'b1);
        // Five zeros complete the surviving group right on the frame end.
        repeat (4) send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'h00, 1'b1);
        // Table at hash zero is still clear: eight hits, flag byte only.
        repeat (8) send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'h80, 1'b0);
        send_item(KIND_DATA, 8'h01, 1'b0);
        send_item(KIND_DATA, 8'h55, 1'b1);
        // Eight zeros closing a frame: the fifth misses on the 80 now stored at hash zero.
        repeat (7) send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'h00, 1'b1);
    endtask

    // Random part: frames mostly replay one of a few stored messages, so the
    // guess table predicts well and flag bits get set; some messages are
    // refreshed, some bytes mutated, and a few clears break frames midway.
    task automatic run_random();
        logic [7:0] pool [4][POOL_DEPTH];
        int         pool_len [4];
        int         sent;
        int         pick;
        int         clear_pos;
        int         clears_left;
        bit         paused;
        logic [7:0] b;
        sent        = 0;
        clears_left = 3;
        paused      = 1'b0;
        for (int p = 0; p < 4; p++) begin
            pool_len[p] = $urandom_range(1, 12);
            for (int k = 0; k < POOL_DEPTH; k++)
                pool[p][k] = 8'($urandom);
        end
        while (sent < RANDOM_BYTES) begin
            if (sent >= QUIET_FROM)
                quiet = 1'b1;
            if (long_holds_asked == 0 && sent >= 80)
                long_holds_asked = 1;
            if (!paused && sent >= 170) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 3);
            if ($urandom_range(0, 4) == 0) begin
                // Refresh a message; now and then a long one spanning groups.
                pool_len[pick] = ($urandom_range(0, 9) == 0) ? POOL_DEPTH
                                                             : $urandom_range(1, 12);
                for (int k = 0; k < POOL_DEPTH; k++)
                    pool[pick][k] = 8'($urandom);
            end
            clear_pos = -1;
            if (clears_left > 0 && $urandom_range(0, 11) == 0)
                clear_pos = $urandom_range(0, pool_len[pick] - 1);
            for (int k = 0; k < pool_len[pick]; k++) begin
                if (k == clear_pos) begin
                    sender_gap();
                    send_item(KIND_CLEAR, 8'($urandom), 1'($urandom));
                    clears_left--;
                end
                b = pool[pick][k];
                if ($urandom_range(0, 15) == 0)
                    b = 8'($urandom);
                sender_gap();
                send_item(KIND_DATA, b, k == pool_len[pick] - 1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        stream = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();

        // Drop valid, let the output drain, then allow a short settling tail.
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (stream.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d data bytes over %0d frames with %0d history clears.",
                 stream.bytes_taken, stream.frames_closed, stream.clears_taken);
        $display("Checked %0d output bytes, %0d flag-only bursts, under random and long stalls.",
                 stream.checked, stream.flag_only_bursts);
        if (stream.pending() != 0)
            $display("%0d expected output bytes never arrived", stream.pending());
        if (stream.mismatches == 0 && stream.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", stream.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pc1c_pkg.sv
hw/rtl/pc1c_burst.sv
hw/rtl/predictor_one_compressor_core.sv
verif/tb.sv
